/* design/mpsm_pkg.sv */
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants of the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

	localparam int NODES_DEF    = 4096;
	localparam int ALPHABET_DEF = 26;
	localparam int KIND_W       = 3;
	localparam int SYM_W        = 5;
	localparam int TOTAL_W      = 16;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PSYM  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PEND  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BUILD = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TSYM  = 3'd4;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_PSYM,
		OP_PEND,
		OP_BUILD,
		OP_TSYM,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SYM_W-1:0] sym;
	} front_item_t;

	typedef struct packed {
		logic        valid;
		front_item_t item;
	} front_q_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ROW,
		ST_PRD,
		ST_PCHK,
		ST_ERD,
		ST_ECHK,
		ST_TRD,
		ST_TCHK,
		ST_ORD,
		ST_OCHK,
		ST_BSYM_RD,
		ST_BSYM_CHK,
		ST_BW_RD,
		ST_BW_CHK,
		ST_BNEXT,
		ST_BPOP_RD,
		ST_BPOP_Q,
		ST_BPOP_F,
		ST_MARK,
		ST_DONE
	} state_t;

endpackage

/* design/mpsm_front.sv */
// ----------------------------------------------------------------------------
// mpsm_front
// Accepts items, classifies them into operations and holds them in a
// two-entry queue toward the engine.
// ----------------------------------------------------------------------------
module mpsm_front #(
	parameter int ALPHABET = mpsm_pkg::ALPHABET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [mpsm_pkg::KIND_W-1:0] kind,
	input  logic [mpsm_pkg::SYM_W-1:0]  symbol,
	output mpsm_pkg::front_q_t          q_head,
	input  logic                        q_pop
);
	import mpsm_pkg::*;

	front_item_t ent_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	front_item_t cls;
	logic        sym_ok;
	logic        push;
	logic        pop;

	assign sym_ok = {4'b0, symbol} < 9'(ALPHABET);

	always_comb begin
		cls.sym = symbol;
		case (kind)
			KIND_CLEAR: cls.op = OP_CLEAR;
			KIND_PSYM:  cls.op = sym_ok ? OP_PSYM : OP_NOP;
			KIND_PEND:  cls.op = OP_PEND;
			KIND_BUILD: cls.op = OP_BUILD;
			KIND_TSYM:  cls.op = sym_ok ? OP_TSYM : OP_NOP;
			default:    cls.op = OP_NOP;
		endcase
	end

	assign in_ready     = (cnt_q != 2'd2);
	assign push         = in_valid && in_ready;
	assign pop          = q_pop && (cnt_q != 2'd0);
	assign q_head.valid = (cnt_q != 2'd0);
	assign q_head.item  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* design/mpsm_back.sv */
// ----------------------------------------------------------------------------
// mpsm_back
// Sequencer that owns the trie, link, count, mark and build queue memories,
// carries out one operation at a time and holds the result register.
// ----------------------------------------------------------------------------
module mpsm_back #(
	parameter int NODES    = mpsm_pkg::NODES_DEF,
	parameter int ALPHABET = mpsm_pkg::ALPHABET_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mpsm_pkg::front_q_t           q_head,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mpsm_pkg::TOTAL_W-1:0] total_found,
	output logic                         status
);
	import mpsm_pkg::*;

	localparam int NW = $clog2(NODES);
	localparam int AW = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
	localparam int CW = $clog2(NODES * ALPHABET);
	localparam logic [AW-1:0] S_LAST = AW'(ALPHABET - 1);

	logic [NW-1:0]      child_mem [NODES*ALPHABET];
	logic [TOTAL_W-1:0] cnt_mem   [NODES];
	logic [NW-1:0]      fail_mem  [NODES];
	logic               mark_mem  [NODES];
	logic [NW-1:0]      queue_mem [NODES];

	state_t state_q, state_d;

	logic [NW:0]        nu_q;
	logic [NW-1:0]      ins_q, match_q, row_q, p_q, x_q, y_q, fx_q, head_q, tail_q, n_q;
	logic [AW-1:0]      s_q;
	logic [TOTAL_W-1:0] total_q;
	logic               stat_q, resp_q, root_q, ov_q;
	logic [TOTAL_W-1:0] res_total_q;
	logic               res_stat_q;

	logic [NW-1:0]      c_rd, f_rd, q_rd;
	logic [TOTAL_W-1:0] n_rd;
	logic               m_rd;

	logic               c_we, f_we, n_we, m_we, q_we;
	logic [NW-1:0]      c_rnode, c_wnode, c_wdata, f_raddr, f_waddr, f_wdata;
	logic [NW-1:0]      n_raddr, n_waddr, q_waddr;
	logic [TOTAL_W-1:0] n_wdata;
	logic [NW-1:0]      m_waddr;
	logic               m_wdata;
	logic [CW-1:0]      c_raddr, c_waddr;

	logic               room, walk_on, out_free, mark_last;
	logic [TOTAL_W:0]   sum;

	assign room      = nu_q < (NW+1)'(NODES);
	assign walk_on   = (p_q != '0) && (c_rd == '0);
	assign out_free  = !ov_q || out_ready;
	assign mark_last = ({1'b0, n_q} == nu_q - 1'b1);
	assign sum       = {1'b0, total_q} + {1'b0, n_rd};

	assign q_pop       = (state_q == ST_IDLE) && q_head.valid;
	assign out_valid   = ov_q;
	assign total_found = res_total_q;
	assign status      = res_stat_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_head.valid) begin
					case (q_head.item.op)
						OP_CLEAR: state_d = ST_ROW;
						OP_PSYM:  state_d = ST_PRD;
						OP_PEND:  state_d = ST_ERD;
						OP_BUILD: state_d = ST_BSYM_RD;
						OP_TSYM:  state_d = ST_TRD;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_ROW:      if (s_q == S_LAST) state_d = resp_q ? ST_DONE : ST_IDLE;
			ST_PRD:      state_d = ST_PCHK;
			ST_PCHK:     state_d = (c_rd == '0 && room) ? ST_ROW : ST_DONE;
			ST_ERD:      state_d = ST_ECHK;
			ST_ECHK:     state_d = ST_DONE;
			ST_TRD:      state_d = ST_TCHK;
			ST_TCHK:     state_d = walk_on ? ST_TRD : ST_ORD;
			ST_ORD:      state_d = (p_q == '0) ? ST_DONE : ST_OCHK;
			ST_OCHK:     state_d = m_rd ? ST_DONE : ST_ORD;
			ST_BSYM_RD:  state_d = ST_BSYM_CHK;
			ST_BSYM_CHK: state_d = (c_rd == '0 || root_q) ? ST_BNEXT : ST_BW_RD;
			ST_BW_RD:    state_d = ST_BW_CHK;
			ST_BW_CHK:   state_d = walk_on ? ST_BW_RD : ST_BNEXT;
			ST_BNEXT: begin
				if (s_q != S_LAST) state_d = ST_BSYM_RD;
				else state_d = (head_q == tail_q) ? ST_MARK : ST_BPOP_RD;
			end
			ST_BPOP_RD:  state_d = ST_BPOP_Q;
			ST_BPOP_Q:   state_d = ST_BPOP_F;
			ST_BPOP_F:   state_d = ST_BSYM_RD;
			ST_MARK:     if (mark_last) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		c_we = 1'b0; c_wnode = row_q; c_wdata = '0;
		c_rnode = p_q;
		f_we = 1'b0; f_waddr = y_q; f_wdata = '0;
		f_raddr = p_q;
		n_we = 1'b0; n_waddr = ins_q; n_wdata = '0;
		n_raddr = p_q;
		m_we = 1'b0; m_waddr = p_q; m_wdata = 1'b0;
		q_we = 1'b0; q_waddr = tail_q;
		case (state_q)
			ST_ROW: c_we = 1'b1;
			ST_PRD: c_rnode = ins_q;
			ST_PCHK: begin
				if (c_rd == '0 && room) begin
					c_we    = 1'b1;
					c_wnode = ins_q;
					c_wdata = nu_q[NW-1:0];
					f_we    = 1'b1;
					f_waddr = nu_q[NW-1:0];
					n_we    = 1'b1;
					n_waddr = nu_q[NW-1:0];
					m_we    = 1'b1;
					m_waddr = nu_q[NW-1:0];
				end
			end
			ST_ERD: n_raddr = ins_q;
			ST_ECHK: begin
				n_we    = (ins_q != '0) && (n_rd != '1);
				n_wdata = n_rd + 1'b1;
			end
			ST_OCHK: begin
				m_we    = !m_rd;
				m_wdata = 1'b1;
			end
			ST_BSYM_RD: c_rnode = x_q;
			ST_BSYM_CHK: begin
				if (root_q && c_rd != '0) begin
					f_we    = 1'b1;
					f_waddr = c_rd;
					q_we    = 1'b1;
				end
			end
			ST_BW_CHK: begin
				if (!walk_on) begin
					f_we    = 1'b1;
					f_wdata = c_rd;
					q_we    = 1'b1;
				end
			end
			ST_BPOP_Q: f_raddr = q_rd;
			ST_MARK: begin
				m_we    = 1'b1;
				m_waddr = n_q;
			end
			default: ;
		endcase
	end

	assign c_raddr = CW'(c_rnode) * CW'(ALPHABET) + CW'(s_q);
	assign c_waddr = CW'(c_wnode) * CW'(ALPHABET) + CW'(s_q);

	always_ff @(posedge clk) begin
		if (c_we) child_mem[c_waddr] <= c_wdata;
		c_rd <= child_mem[c_raddr];
	end

	always_ff @(posedge clk) begin
		if (f_we) fail_mem[f_waddr] <= f_wdata;
		f_rd <= fail_mem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (n_we) cnt_mem[n_waddr] <= n_wdata;
		n_rd <= cnt_mem[n_raddr];
	end

	always_ff @(posedge clk) begin
		if (m_we) mark_mem[m_waddr] <= m_wdata;
		m_rd <= mark_mem[p_q];
	end

	always_ff @(posedge clk) begin
		if (q_we) queue_mem[q_waddr] <= (state_q == ST_BSYM_CHK) ? c_rd : y_q;
		q_rd <= queue_mem[head_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ROW;
			nu_q    <= (NW+1)'(1);
			ins_q   <= '0;
			match_q <= '0;
			total_q <= '0;
			row_q   <= '0;
			s_q     <= '0;
			resp_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_head.valid) begin
						resp_q <= 1'b1;
						s_q    <= AW'(q_head.item.sym);
						if (q_head.item.op == OP_CLEAR) begin
							row_q   <= '0;
							s_q     <= '0;
							nu_q    <= (NW+1)'(1);
							ins_q   <= '0;
							match_q <= '0;
							total_q <= '0;
						end
						if (q_head.item.op == OP_BUILD) s_q <= '0;
					end
				end
				ST_ROW: s_q <= s_q + 1'b1;
				ST_PCHK: begin
					if (c_rd != '0) begin
						ins_q <= c_rd;
					end else if (room) begin
						ins_q <= nu_q[NW-1:0];
						row_q <= nu_q[NW-1:0];
						nu_q  <= nu_q + 1'b1;
						s_q   <= '0;
					end
				end
				ST_ECHK: ins_q <= '0;
				ST_TCHK: if (!walk_on) match_q <= c_rd;
				ST_OCHK: if (!m_rd) total_q <= sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
				ST_BNEXT: if (s_q != S_LAST) s_q <= s_q + 1'b1;
				ST_BPOP_F: s_q <= '0;
				ST_MARK: begin
					if (mark_last) begin
						match_q <= '0;
						total_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				stat_q <= 1'b0;
				p_q    <= match_q;
				x_q    <= '0;
				root_q <= 1'b1;
				head_q <= '0;
				tail_q <= '0;
			end
			ST_PCHK: if (c_rd == '0 && !room) stat_q <= 1'b1;
			ST_TCHK: p_q <= walk_on ? f_rd : c_rd;
			ST_OCHK: p_q <= f_rd;
			ST_BSYM_CHK: begin
				y_q <= c_rd;
				p_q <= fx_q;
				if (root_q && c_rd != '0) tail_q <= tail_q + 1'b1;
			end
			ST_BW_CHK: begin
				if (walk_on) p_q <= f_rd;
				else tail_q <= tail_q + 1'b1;
			end
			ST_BNEXT: if (s_q == S_LAST) n_q <= '0;
			ST_BPOP_RD: head_q <= head_q + 1'b1;
			ST_BPOP_Q: begin
				x_q    <= q_rd;
				root_q <= 1'b0;
			end
			ST_BPOP_F: fx_q <= f_rd;
			ST_MARK: n_q <= n_q + 1'b1;
			ST_DONE: begin
				if (out_free) begin
					res_total_q <= total_q;
					res_stat_q  <= stat_q;
				end
			end
			default: ;
		endcase
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE)
		else $error("item taken from queue outside idle");

	a_row_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROW |-> {1'b0, row_q} < nu_q)
		else $error("row sweep on unallocated node");

	a_ins_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ins_q} < nu_q)
		else $error("insert position beyond allocated nodes");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && ov_q && !out_ready) |=> state_q == ST_DONE)
		else $error("result overwritten while output stalled");

endmodule

/* design/multi_pattern_string_matcher.sv */
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick keyword engine: trie build, failure links, text matching.
// ----------------------------------------------------------------------------
// One result per item; items are carried out one at a time by the engine
// while a two-entry queue keeps accepting. After reset the root row of the
// trie is swept clear before the first item runs. A pattern symbol that
// allocates a node also sweeps the new node's row clear; a text symbol
// follows failure links until it finds a child, then follows failure links
// from the new node and adds the count of each node not yet reported; a
// build links the trie breadth first and then sweeps the marks of all
// allocated nodes clear. A stalled result holds the engine.
module multi_pattern_string_matcher #(
	parameter int NODES    = mpsm_pkg::NODES_DEF,
	parameter int ALPHABET = mpsm_pkg::ALPHABET_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mpsm_pkg::KIND_W-1:0]  kind,
	input  logic [mpsm_pkg::SYM_W-1:0]   symbol,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mpsm_pkg::TOTAL_W-1:0] total_found,
	output logic                         status
);
	import mpsm_pkg::*;

	front_q_t q_head;
	logic     q_pop;

	mpsm_front #(
		.ALPHABET(ALPHABET)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind    (kind),
		.symbol  (symbol),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	mpsm_back #(
		.NODES   (NODES),
		.ALPHABET(ALPHABET)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.total_found(total_found),
		.status     (status)
	);

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives trie-building, link-building and text items into the matcher with
// bursty input and a stalling output, predicts every running total and
// status bit, and compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import mpsm_pkg::*;

	localparam int NODES    = NODES_DEF;
	localparam int ALPH     = ALPHABET_DEF;
	localparam int COUNT_MX = 65535;

	typedef struct {
		logic [TOTAL_W-1:0] total;
		logic               stat;
	} match_res_t;

	class match_scoreboard;
		match_res_t pending[$];
		int errors = 0;

		function void note(match_res_t r);
			pending.push_back(r);
		endfunction

		function void check(logic [TOTAL_W-1:0] total, logic stat);
			match_res_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result total=%0d status=%0d", $time, total, stat);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (total !== e.total) begin
				$display("%0t total_found expected %0d actual %0d", $time, e.total, total);
				errors++;
			end
			if (stat !== e.stat) begin
				$display("%0t status expected %0d actual %0d", $time, e.stat, stat);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_ready;
	logic [KIND_W-1:0]   kind = KIND_CLEAR;
	logic [SYM_W-1:0]    symbol = '0;
	logic                out_valid;
	logic                out_ready = 0;
	logic [TOTAL_W-1:0]  total_found;
	logic                status;

	multi_pattern_string_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .symbol(symbol),
		.out_valid(out_valid), .out_ready(out_ready),
		.total_found(total_found), .status(status)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	match_scoreboard sb = new();

	// predictor state
	logic [11:0] child [0:NODES*ALPH-1];
	int          pcount [0:NODES-1];
	int          flink [0:NODES-1];
	bit          marked [0:NODES-1];
	int          nodes_used, ins_pos, match_pos, run_total;

	function automatic void wipe_node(int n);
		for (int s = 0; s < ALPH; s++) child[n*ALPH+s] = '0;
		pcount[n] = 0;
		flink[n] = 0;
		marked[n] = 0;
	endfunction

	function automatic void link_trie();
		int bfs[$];
		int x, y, p, steps;
		for (int s = 0; s < ALPH; s++)
			if (child[s] != 0) begin
				flink[child[s]] = 0;
				bfs.push_back(child[s]);
			end
		while (bfs.size() > 0) begin
			x = bfs.pop_front();
			for (int s = 0; s < ALPH; s++) begin
				y = child[x*ALPH+s];
				if (y == 0) continue;
				p = flink[x];
				steps = 0;
				while (p != 0 && child[p*ALPH+s] == 0 && steps < NODES) begin
					p = flink[p];
					steps++;
				end
				flink[y] = child[p*ALPH+s];
				bfs.push_back(y);
			end
		end
		for (int n = 0; n < NODES; n++) marked[n] = 0;
		match_pos = 0;
		run_total = 0;
	endfunction

	function automatic void scan_letter(int s);
		int p, steps;
		p = match_pos;
		steps = 0;
		while (p != 0 && child[p*ALPH+s] == 0 && steps < NODES) begin
			p = flink[p];
			steps++;
		end
		p = child[p*ALPH+s];
		match_pos = p;
		steps = 0;
		while (p != 0 && !marked[p] && steps < NODES) begin
			run_total += pcount[p];
			if (run_total > COUNT_MX) run_total = COUNT_MX;
			marked[p] = 1;
			p = flink[p];
			steps++;
		end
	endfunction

	function automatic match_res_t predict_match(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s);
		match_res_t r;
		int c;
		r.stat = 0;
		case (k)
			KIND_CLEAR: begin
				wipe_node(0);
				nodes_used = 1;
				ins_pos = 0;
				match_pos = 0;
				run_total = 0;
			end
			KIND_PSYM: if (s < ALPH) begin
				c = child[ins_pos*ALPH+s];
				if (c == 0) begin
					if (nodes_used < NODES) begin
						c = nodes_used++;
						wipe_node(c);
						child[ins_pos*ALPH+s] = 12'(c);
						ins_pos = c;
					end else r.stat = 1;
				end else ins_pos = c;
			end
			KIND_PEND: begin
				if (ins_pos != 0 && pcount[ins_pos] < COUNT_MX) pcount[ins_pos]++;
				ins_pos = 0;
			end
			KIND_BUILD: link_trie();
			KIND_TSYM: if (s < ALPH) scan_letter(s);
			default: ;
		endcase
		r.total = run_total[TOTAL_W-1:0];
		return r;
	endfunction

	// sender
	int burst_left = 0;
	int sent = 0;
	bit bursty = 1;

	task automatic send_item(logic [KIND_W-1:0] k, logic [SYM_W-1:0] s);
		if (bursty && burst_left == 0) begin
			repeat ($urandom_range(0, 6)) begin
				@(negedge clk);
				in_valid <= 0;
			end
			burst_left = $urandom_range(1, 20);
		end
		@(negedge clk);
		in_valid <= 1;
		kind <= k;
		symbol <= s;
		do @(posedge clk); while (!in_ready);
		sb.note(predict_match(k, s));
		if (burst_left > 0) burst_left--;
		sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// receiver
	int stall_mode = 0;
	int cyc = 0;
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_ready <= 1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= (cyc % 4 == 0);
		endcase
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check(total_found, status);

	initial begin
		#300000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int lim, npat, plen, ntext;
		nodes_used = 1; ins_pos = 0; match_pos = 0; run_total = 0;
		for (int n = 0; n < NODES*ALPH; n++) child[n] = '0;
		for (int n = 0; n < NODES; n++) wipe_node(n);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: basic patterns, empty pattern, ignored items
		send_item(KIND_PEND, 5'd0);
		send_item(KIND_PSYM, 5'd0);
		send_item(KIND_PSYM, 5'd25);
		send_item(KIND_PEND, 5'd0);
		send_item(KIND_PSYM, 5'd25);
		send_item(KIND_PEND, 5'd0);
		send_item(KIND_PSYM, 5'd31);
		send_item(KIND_PSYM, 5'd26);
		send_item(3'd5, 5'd3);
		send_item(3'd6, 5'd0);
		send_item(3'd7, 5'd31);
		send_item(KIND_BUILD, 5'd0);
		send_item(KIND_TSYM, 5'd0);
		send_item(KIND_TSYM, 5'd25);
		send_item(KIND_TSYM, 5'd25);
		send_item(KIND_TSYM, 5'd30);
		send_item(KIND_TSYM, 5'd1);
		send_item(KIND_BUILD, 5'd0);
		send_item(KIND_TSYM, 5'd25);
		send_item(KIND_CLEAR, 5'd0);

		// repeated pattern counts, back to back
		bursty = 0;
		send_item(KIND_PSYM, 5'd1);
		send_item(KIND_PEND, 5'd0);
		send_item(KIND_PSYM, 5'd2);
		repeat (20) send_item(KIND_PEND, 5'd0);
		send_item(KIND_PSYM, 5'd2);
		send_item(KIND_PEND, 5'd0);
		send_item(KIND_BUILD, 5'd0);
		send_item(KIND_TSYM, 5'd1);
		send_item(KIND_TSYM, 5'd2);
		send_item(KIND_CLEAR, 5'd0);
		bursty = 1;
		drain_results();

		// random sessions
		sent = 0;
		while (sent < 1800) begin
			if (sent > 900 && sent < 960) drain_results();
			if ($urandom_range(0, 3) == 0) send_item(KIND_CLEAR, 5'($urandom_range(0, 31)));
			lim = $urandom_range(0, 3) == 0 ? ALPH : $urandom_range(2, 4);
			npat = $urandom_range(1, 6);
			repeat (npat) begin
				plen = $urandom_range(0, 4);
				repeat (plen) send_item(KIND_PSYM, 5'($urandom_range(0, lim - 1)));
				if ($urandom_range(0, 9) == 0)
					send_item(KIND_PSYM, 5'($urandom_range(26, 31)));
				send_item(KIND_PEND, 5'($urandom_range(0, 31)));
			end
			send_item(KIND_BUILD, 5'($urandom_range(0, 31)));
			ntext = $urandom_range(10, 40);
			repeat (ntext) begin
				if ($urandom_range(0, 19) == 0)
					send_item(3'($urandom_range(5, 7)), 5'($urandom_range(0, 31)));
				else if ($urandom_range(0, 19) == 0)
					send_item(KIND_TSYM, 5'($urandom_range(0, 31)));
				else
					send_item(KIND_TSYM, 5'($urandom_range(0, lim - 1)));
			end
		end

		drain_results();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
